// ===== hdl/awc_pkg.sv =====
// ----------------------------------------------------------------------------
// awc_pkg
// Shared codes and types of the anagram window counter: item kinds,
// histogram operation codes and the control structs between the modules.
// ----------------------------------------------------------------------------
package awc_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [1:0] KIND_PATTERN = 2'd0;
  localparam logic [1:0] KIND_TEXT    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PAT_INC,
    OP_WIN_INC,
    OP_WIN_DEC
  } hist_op_e;

  // One histogram operation as issued to the update pipe
  typedef struct packed {
    logic     valid;
    hist_op_e op;
    logic     emit;   // this operation closes a text item and yields its result
    logic     full;   // the window is full once this item is in
  } hist_ctl_t;

  typedef struct packed {
    logic clearing;   // clearing pass over the histogram memory runs
    logic busy;       // an operation sits in the modify stage
  } hist_status_t;

  typedef struct packed {
    logic               match;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// ===== hdl/awc_ram.sv =====
// ----------------------------------------------------------------------------
// awc_ram
// Simple dual-port synchronous RAM: one write and one read port, registered
// read data, read of the entry being written returns the old contents.
// ----------------------------------------------------------------------------
module awc_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/awc_hist_pipe.sv =====
// ----------------------------------------------------------------------------
// awc_hist_pipe
// Histogram memory with read-modify-write pipe. Each entry holds the pattern
// count and the window count of one value. Keeps the mismatch counter and the
// running match count, and runs the clearing pass after reset and restart.
// ----------------------------------------------------------------------------
module awc_hist_pipe #(
  parameter int unsigned VALUE_COUNT = 256,
  parameter int unsigned MAX_PATTERN = 128,
  localparam int unsigned VW = $clog2(VALUE_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  awc_pkg::hist_ctl_t    issue_i,
  input  logic [VW-1:0]         issue_addr_i,
  input  logic                  clear_i,
  output awc_pkg::hist_status_t status_o,
  output logic                  res_valid_o,
  output awc_pkg::result_t      res_o
);

  // Window count briefly reaches pattern length plus one before the eviction
  localparam int unsigned CW = $clog2(MAX_PATTERN + 2);
  localparam int unsigned DW = $clog2(VALUE_COUNT + 1);
  localparam int unsigned EW = 2 * CW;
  localparam logic [VW-1:0] LAST_ADDR = VW'(VALUE_COUNT - 1);

  awc_pkg::hist_ctl_t s1_ctl_q;
  logic [VW-1:0]      s1_addr_q;
  logic               fwd_hit_q;
  logic [EW-1:0]      fwd_data_q;
  logic [DW-1:0]      diff_q, diff_d;
  logic [awc_pkg::COUNT_W-1:0] matches_q, matches_d;
  logic               clearing_q;
  logic [VW-1:0]      clr_cnt_q;

  logic [EW-1:0] rdata;
  logic [EW-1:0] entry;
  logic [EW-1:0] entry_new;
  logic [CW-1:0] p_cnt, w_cnt, p_new, w_new;
  logic          s1_writes;
  logic          differed, differs;
  logic          match;
  logic          ram_we;
  logic [VW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;

  assign s1_writes = s1_ctl_q.valid && (s1_ctl_q.op != awc_pkg::OP_NONE);

  assign ram_we    = clearing_q || s1_writes;
  assign ram_waddr = clearing_q ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = clearing_q ? '0 : entry_new;

  awc_ram #(
    .DEPTH (VALUE_COUNT),
    .WIDTH (EW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue_i.valid),
    .raddr_i (issue_addr_i),
    .rdata_o (rdata)
  );

  // Take the entry written last cycle when the memory still shows the old one
  assign entry = fwd_hit_q ? fwd_data_q : rdata;
  assign p_cnt = entry[EW-1:CW];
  assign w_cnt = entry[CW-1:0];

  always_comb begin
    p_new = p_cnt;
    w_new = w_cnt;
    unique case (s1_ctl_q.op)
      awc_pkg::OP_PAT_INC: p_new = p_cnt + 1'b1;
      awc_pkg::OP_WIN_INC: w_new = w_cnt + 1'b1;
      awc_pkg::OP_WIN_DEC: w_new = (w_cnt != '0) ? w_cnt - 1'b1 : w_cnt;
      awc_pkg::OP_NONE:    ;
    endcase
  end

  assign entry_new = {p_new, w_new};
  assign differed  = p_cnt != w_cnt;
  assign differs   = p_new != w_new;

  always_comb begin
    diff_d = diff_q;
    if (s1_writes) begin
      priority if (differs && !differed) begin
        diff_d = diff_q + 1'b1;
      end else if (!differs && differed && diff_q != '0) begin
        diff_d = diff_q - 1'b1;
      end
    end
  end

  assign match = s1_ctl_q.full && (s1_ctl_q.op != awc_pkg::OP_NONE) && (diff_d == '0);

  always_comb begin
    matches_d = matches_q;
    if (s1_ctl_q.valid && s1_ctl_q.emit && match && matches_q != awc_pkg::COUNT_MAX) begin
      matches_d = matches_q + 1'b1;
    end
  end

  assign res_valid_o = s1_ctl_q.valid && s1_ctl_q.emit;
  assign res_o.match = match;
  assign res_o.count = matches_d;

  assign status_o.clearing = clearing_q;
  assign status_o.busy     = s1_ctl_q.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q   <= '0;
      fwd_hit_q  <= 1'b0;
      diff_q     <= '0;
      matches_q  <= '0;
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      s1_ctl_q  <= issue_i;
      fwd_hit_q <= issue_i.valid && s1_writes && (issue_addr_i == s1_addr_q);
      if (clear_i) begin
        diff_q     <= '0;
        matches_q  <= '0;
        clearing_q <= 1'b1;
        clr_cnt_q  <= '0;
      end else begin
        diff_q    <= diff_d;
        matches_q <= matches_d;
        if (clearing_q) begin
          if (clr_cnt_q == LAST_ADDR) begin
            clearing_q <= 1'b0;
          end else begin
            clr_cnt_q <= clr_cnt_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= issue_addr_i;
    fwd_data_q <= entry_new;
  end

endmodule

// ===== hdl/awc_out_queue.sv =====
// ----------------------------------------------------------------------------
// awc_out_queue
// Four-entry result queue between the update pipe and the output channel.
// Space is reserved upstream, so a push always finds a free slot.
// ----------------------------------------------------------------------------
module awc_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  awc_pkg::result_t push_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output awc_pkg::result_t out_data_o
);

  awc_pkg::result_t slot_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;

  assign out_valid_o = count_q != 3'd0;
  assign out_data_o  = slot_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      unique case ({push_i, pop})
        2'b10:   count_q <= count_q + 3'd1;
        2'b01:   count_q <= count_q - 3'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/anagram_window_counter_unit.sv =====
// ----------------------------------------------------------------------------
// anagram_window_counter_unit
// Counts the text windows whose multiset of values equals the pattern.
// ----------------------------------------------------------------------------
// Pattern items build a histogram; each text item then slides a window of
// pattern length over the text and returns a match flag and a saturating
// match count. Both counts of a value share one entry of a histogram memory
// with one write port, updated by read-modify-write with forwarding. A pattern
// item and a text item while the window is filling take one histogram update;
// once the window is full a text item takes two updates, one for the entering
// value and one for the leaving value, read back from a ring memory, and the
// input is held between them. Up to four results may wait at the output
// without stalling the input. After reset and after each restart item a
// clearing pass over all VALUE_COUNT entries zeroes the histogram memory, and
// no item is taken during it.
// ----------------------------------------------------------------------------
module anagram_window_counter_unit #(
  parameter int unsigned MAX_PATTERN = 128,
  parameter int unsigned VALUE_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        window_match_o,
  output logic [15:0] match_count_o
);

  localparam int unsigned VW = $clog2(VALUE_COUNT);
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LW-1:0] PLEN_MAX = LW'(MAX_PATTERN);

  typedef logic [VW-1:0] mod_lut_t [256];

  function automatic mod_lut_t build_mod_lut();
    mod_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = VW'(i % VALUE_COUNT);
    end
    return lut;
  endfunction

  localparam mod_lut_t MOD_LUT = build_mod_lut();

  logic [LW-1:0] plen_q, plen_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [PW-1:0] ring_ptr_q, ring_ptr_d;
  logic          text_started_q, text_started_d;
  logic          pend_q, pend_d;
  logic [2:0]    outstanding_q;

  logic          in_xfer, out_xfer;
  logic          is_text, is_restart;
  logic [VW-1:0] value_mod;
  logic [VW-1:0] ring_rdata;
  logic          ring_access;
  logic          evict;
  logic [LW-1:0] fill_inc;
  logic [LW-1:0] ptr_inc;

  awc_pkg::hist_ctl_t    issue;
  logic [VW-1:0]         issue_addr;
  awc_pkg::hist_status_t hist_status;
  logic                  res_valid;
  awc_pkg::result_t      res;
  awc_pkg::result_t      out_data;

  assign value_mod  = MOD_LUT[value_i];
  assign is_text    = kind_i == awc_pkg::KIND_TEXT;
  assign is_restart = kind_i == awc_pkg::KIND_RESTART;

  // Hold text while four results are owed; hold restart until the pipe drains
  assign in_ready_o = !hist_status.clearing && !pend_q
                      && !(is_text && outstanding_q == 3'd4)
                      && !(is_restart && hist_status.busy);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  assign evict       = fill_q == plen_q;
  assign fill_inc    = fill_q + 1'b1;
  assign ptr_inc     = LW'(ring_ptr_q) + 1'b1;
  assign ring_access = in_xfer && is_text && plen_q != '0;

  awc_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (VW)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_access),
    .waddr_i (ring_ptr_q),
    .wdata_i (value_mod),
    .re_i    (ring_access),
    .raddr_i (ring_ptr_q),
    .rdata_o (ring_rdata)
  );

  // Front end: window bookkeeping and operation issue
  always_comb begin
    plen_d         = plen_q;
    fill_d         = fill_q;
    ring_ptr_d     = ring_ptr_q;
    text_started_d = text_started_q;
    pend_d         = 1'b0;
    if (in_xfer) begin
      unique case (kind_i)
        awc_pkg::KIND_PATTERN: begin
          if (!text_started_q && plen_q < PLEN_MAX) begin
            plen_d = plen_q + 1'b1;
          end
        end
        awc_pkg::KIND_TEXT: begin
          text_started_d = 1'b1;
          if (plen_q != '0) begin
            if (evict) begin
              pend_d = 1'b1;
            end else begin
              fill_d = fill_inc;
            end
            ring_ptr_d = (ptr_inc >= plen_q) ? '0 : PW'(ptr_inc);
          end
        end
        awc_pkg::KIND_RESTART: begin
          plen_d         = '0;
          fill_d         = '0;
          ring_ptr_d     = '0;
          text_started_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    issue      = '0;
    issue.op   = awc_pkg::OP_NONE;
    issue_addr = value_mod;
    if (pend_q) begin
      // second half of a text item: drop the value leaving the window
      issue.valid = 1'b1;
      issue.op    = awc_pkg::OP_WIN_DEC;
      issue.emit  = 1'b1;
      issue.full  = 1'b1;
      issue_addr  = ring_rdata;
    end else if (in_xfer) begin
      unique case (kind_i)
        awc_pkg::KIND_PATTERN: begin
          if (!text_started_q && plen_q < PLEN_MAX) begin
            issue.valid = 1'b1;
            issue.op    = awc_pkg::OP_PAT_INC;
          end
        end
        awc_pkg::KIND_TEXT: begin
          issue.valid = 1'b1;
          issue.emit  = 1'b1;
          if (plen_q != '0) begin
            issue.op   = awc_pkg::OP_WIN_INC;
            issue.emit = !evict;
            issue.full = !evict && (fill_inc == plen_q);
          end
        end
        default: ;
      endcase
    end
  end

  awc_hist_pipe #(
    .VALUE_COUNT (VALUE_COUNT),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_hist_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .issue_addr_i (issue_addr),
    .clear_i      (in_xfer && is_restart),
    .status_o     (hist_status),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  awc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign window_match_o = out_data.match;
  assign match_count_o  = out_data.count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q         <= '0;
      fill_q         <= '0;
      ring_ptr_q     <= '0;
      text_started_q <= 1'b0;
      pend_q         <= 1'b0;
      outstanding_q  <= 3'd0;
    end else begin
      plen_q         <= plen_d;
      fill_q         <= fill_d;
      ring_ptr_q     <= ring_ptr_d;
      text_started_q <= text_started_d;
      pend_q         <= pend_d;
      unique case ({in_xfer && is_text, out_xfer})
        2'b10:   outstanding_q <= outstanding_q + 3'd1;
        2'b01:   outstanding_q <= outstanding_q - 3'd1;
        default: outstanding_q <= outstanding_q;
      endcase
    end
  end

  a_outstanding_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 3'd4)
    else $error("more results owed than the output queue holds");

  a_no_issue_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_status.clearing |-> !issue.valid)
    else $error("histogram operation issued during clearing pass");

  a_pend_after_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(in_xfer && is_text))
    else $error("eviction step without a preceding text transfer");

  a_result_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outstanding_q != 3'd0)
    else $error("result offered that no text item is owed");

endmodule
